// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Both macros expect clk_i and rst_ni in scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MCSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define MCSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/mcsp_pkg.sv =====
// Types and constants of the mesh chunk stream parser.
// No dependencies; used by every module of the block.
`default_nettype none

package mcsp_pkg;

  typedef enum logic [2:0] {
    PhHeader = 3'd0,
    PhName   = 3'd1,
    PhVcount = 3'd2,
    PhVert   = 3'd3,
    PhFcount = 3'd4,
    PhFace   = 3'd5,
    PhSkip   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KindName   = 3'd0,
    KindVcount = 3'd1,
    KindVert   = 3'd2,
    KindFcount = 3'd3,
    KindFace   = 3'd4,
    KindBadLen = 3'd5
  } kind_e;

  localparam logic [15:0] IdMain    = 16'h4d4d;
  localparam logic [15:0] IdEdit    = 16'h3d3d;
  localparam logic [15:0] IdObject  = 16'h4000;
  localparam logic [15:0] IdTriMesh = 16'h4100;
  localparam logic [15:0] IdVerts   = 16'h4110;
  localparam logic [15:0] IdFaces   = 16'h4120;
  localparam logic [31:0] HdrLen    = 32'd6;
  localparam logic [4:0]  NameLimit = 5'd20;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] chunk_tag;
    logic [15:0] item_index;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    logic [7:0]  name_char;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } result_t;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  byte_pos;
    logic        total_nz;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/mcsp_parser.sv =====
// Parse state and per-byte step logic of the chunk parser.
// Depends on mcsp_pkg.
`default_nettype none

module mcsp_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,   // commit the byte below
  input  wire logic [7:0]        byte_i,
  input  wire logic              start_i,
  output mcsp_pkg::result_t      result_o, // result of the byte below
  output mcsp_pkg::status_t      status_o
);

  mcsp_pkg::phase_e phase_q, phase_d, phase_c;
  logic [47:0] hdr_q, hdr_d, hdr_c, hdr_base;
  logic [3:0]  pos_q, pos_d, pos_c;
  logic [15:0] index_q, index_d, index_c;
  logic [15:0] total_q, total_d, total_c;
  logic [31:0] skip_q, skip_d, skip_c;
  logic [63:0] low_q, low_d, low_c;
  logic [31:0] high_q, high_d, high_c;
  logic [4:0]  npos_q, npos_d, npos_c;
  logic [2:0]  hpos;
  logic [15:0] id;
  logic [31:0] len;

  always_comb begin
    // a start byte sees the reset state
    phase_c = start_i ? mcsp_pkg::PhHeader : phase_q;
    hdr_c   = start_i ? '0 : hdr_q;
    pos_c   = start_i ? '0 : pos_q;
    index_c = start_i ? '0 : index_q;
    total_c = start_i ? '0 : total_q;
    skip_c  = start_i ? '0 : skip_q;
    low_c   = start_i ? '0 : low_q;
    high_c  = start_i ? '0 : high_q;
    npos_c  = start_i ? '0 : npos_q;

    phase_d = phase_c;
    hdr_d   = hdr_c;
    pos_d   = pos_c;
    index_d = index_c;
    total_d = total_c;
    skip_d  = skip_c;
    low_d   = low_c;
    high_d  = high_c;
    npos_d  = npos_c;
    hdr_base = '0;
    hpos     = '0;
    id       = '0;
    len      = '0;

    result_o = '0;
    result_o.rec.chunk_tag = hdr_c[15:0];

    unique case (phase_c)
      mcsp_pkg::PhName: begin
        result_o.valid          = 1'b1;
        result_o.rec.kind       = mcsp_pkg::KindName;
        result_o.rec.item_index = {11'd0, npos_c};
        result_o.rec.name_char  = byte_i;
        npos_d = npos_c + 5'd1;
        if (byte_i == 8'd0 || npos_d >= mcsp_pkg::NameLimit || npos_d == 5'd0) begin
          phase_d = mcsp_pkg::PhHeader;
          pos_d   = '0;
        end
      end
      mcsp_pkg::PhVcount, mcsp_pkg::PhFcount: begin
        if (pos_c == 4'd0) begin
          total_d = {8'd0, byte_i};
          pos_d   = 4'd1;
        end else begin
          total_d = {byte_i, total_c[7:0]};
          result_o.valid          = 1'b1;
          result_o.rec.kind       = (phase_c == mcsp_pkg::PhVcount) ?
                                    mcsp_pkg::KindVcount : mcsp_pkg::KindFcount;
          result_o.rec.item_index = total_d;
          index_d = '0;
          pos_d   = '0;
          if (total_d == 16'd0) begin
            phase_d = mcsp_pkg::PhHeader;
          end else begin
            phase_d = (phase_c == mcsp_pkg::PhVcount) ? mcsp_pkg::PhVert : mcsp_pkg::PhFace;
          end
        end
      end
      mcsp_pkg::PhVert: begin
        if (pos_c < 4'd8) begin
          low_d[{pos_c[2:0], 3'b000} +: 8] = byte_i;
        end else begin
          high_d[{pos_c[1:0], 3'b000} +: 8] = byte_i;
        end
        pos_d = pos_c + 4'd1;
        if (pos_c >= 4'd11) begin
          result_o.valid          = 1'b1;
          result_o.rec.kind       = mcsp_pkg::KindVert;
          result_o.rec.item_index = index_c;
          result_o.rec.coord_x    = low_c[31:0];
          result_o.rec.coord_y    = low_c[63:32];
          result_o.rec.coord_z    = {byte_i, high_c[23:0]};
          pos_d   = '0;
          index_d = index_c + 16'd1;
          if (index_d == total_c) begin
            phase_d = mcsp_pkg::PhHeader;
          end
        end
      end
      mcsp_pkg::PhFace: begin
        if (pos_c < 4'd6) begin
          low_d[{pos_c[2:0], 3'b000} +: 8] = byte_i;
        end
        pos_d = pos_c + 4'd1;
        if (pos_c >= 4'd7) begin
          // flag word dropped
          result_o.valid          = 1'b1;
          result_o.rec.kind       = mcsp_pkg::KindFace;
          result_o.rec.item_index = index_c;
          result_o.rec.corner_a   = low_c[15:0];
          result_o.rec.corner_b   = low_c[31:16];
          result_o.rec.corner_c   = low_c[47:32];
          pos_d   = '0;
          index_d = index_c + 16'd1;
          if (index_d == total_c) begin
            phase_d = mcsp_pkg::PhHeader;
          end
        end
      end
      mcsp_pkg::PhSkip: begin
        skip_d = (skip_c != 32'd0) ? skip_c - 32'd1 : skip_c;
        if (skip_d == 32'd0) begin
          phase_d = mcsp_pkg::PhHeader;
          pos_d   = '0;
        end
      end
      default: begin
        // header collect; also the unused phase code
        if (pos_c == 4'd0 || pos_c > 4'd5) begin
          hdr_base = '0;
          hpos     = '0;
        end else begin
          hdr_base = hdr_c;
          hpos     = pos_c[2:0];
        end
        hdr_d = hdr_base;
        hdr_d[{hpos, 3'b000} +: 8] = byte_i;
        pos_d = {1'b0, hpos} + 4'd1;
        if (hpos == 3'd5) begin
          pos_d   = '0;
          phase_d = mcsp_pkg::PhHeader;
          id  = hdr_d[15:0];
          len = hdr_d[47:16];
          priority if (id == mcsp_pkg::IdMain || id == mcsp_pkg::IdEdit ||
                       id == mcsp_pkg::IdTriMesh) begin
            // container: next byte opens a child header
          end else if (id == mcsp_pkg::IdObject) begin
            phase_d = mcsp_pkg::PhName;
            npos_d  = '0;
          end else if (id == mcsp_pkg::IdVerts) begin
            phase_d = mcsp_pkg::PhVcount;
          end else if (id == mcsp_pkg::IdFaces) begin
            phase_d = mcsp_pkg::PhFcount;
          end else if (len < mcsp_pkg::HdrLen) begin
            result_o.valid         = 1'b1;
            result_o.rec.kind      = mcsp_pkg::KindBadLen;
            result_o.rec.chunk_tag = id;
          end else if (len > mcsp_pkg::HdrLen) begin
            skip_d  = len - mcsp_pkg::HdrLen;
            phase_d = mcsp_pkg::PhSkip;
          end else begin
            // header-only chunk: nothing to skip
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mcsp_pkg::PhHeader;
      hdr_q   <= '0;
      pos_q   <= '0;
      index_q <= '0;
      total_q <= '0;
      skip_q  <= '0;
      low_q   <= '0;
      high_q  <= '0;
      npos_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      pos_q   <= pos_d;
      index_q <= index_d;
      total_q <= total_d;
      skip_q  <= skip_d;
      low_q   <= low_d;
      high_q  <= high_d;
      npos_q  <= npos_d;
    end
  end

  assign status_o.phase    = phase_q;
  assign status_o.byte_pos = pos_q;
  assign status_o.total_nz = (total_q != 16'd0);

endmodule

`default_nettype wire

// ===== hdl/mcsp_out_stage.sv =====
// Result register of the chunk parser and its master-side stream packing.
// Depends on mcsp_pkg.
`default_nettype none

module mcsp_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,    // take result_i this cycle
  input  wire mcsp_pkg::result_t result_i,
  input  wire logic              tready_i,
  output logic                   tvalid_o,
  output logic [183:0]           tdata_o,
  output logic [2:0]             tuser_o,
  output logic                   busy_o     // holds a result not yet taken
);

  logic               valid_q, valid_d;
  mcsp_pkg::rec_t     rec_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i && result_i.valid) begin
      valid_d = 1'b1;
    end else if (tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && result_i.valid) begin
      rec_q <= result_i.rec;
    end
  end

  assign tvalid_o = valid_q;
  assign busy_o   = valid_q && !tready_i;
  assign tuser_o  = rec_q.kind;
  assign tdata_o  = {rec_q.name_char, rec_q.corner_c, rec_q.corner_b, rec_q.corner_a,
                     rec_q.coord_z, rec_q.coord_y, rec_q.coord_x,
                     rec_q.item_index, rec_q.chunk_tag};

endmodule

`default_nettype wire

// ===== hdl/mesh_chunk_stream_parser_top.sv =====
// Mesh chunk stream parser: takes a little-endian mesh file one byte per word
// and emits name, vertex-count, vertex, face-count, face and malformed-length
// records. Throughput is one byte per cycle, but for the stall described below:
// the byte goes into an input register, the parse logic updates the parse state
// and writes the result register, and the record goes out on the master side
// from that register. The slave side keeps taking bytes while a record waits in
// the result register, as long as the byte in the input register produces no
// record; a record-producing byte waits only for the result register to drain.
// Chunk headers other than malformed-length ones, skipped bodies and dropped
// face flags produce no words. tuser_i = 1 restarts the parser at a chunk
// header with that byte as header byte 0.
// Depends on mcsp_pkg, mcsp_parser, mcsp_out_stage and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mesh_chunk_stream_parser_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic         s_axis_tuser_i,   // [0] stream_start
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [15:0] chunk_tag, [31:16] item_index, [63:32] coord_x, [95:64] coord_y,
  // [127:96] coord_z, [143:128] corner_a, [159:144] corner_b,
  // [175:160] corner_c, [183:176] name_char
  output logic [183:0]      m_axis_tdata_o,
  output logic [2:0]        m_axis_tuser_o    // [2:0] record_kind
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  logic               adv;     // byte in input register is parsed this cycle
  logic               out_busy;
  mcsp_pkg::result_t  result;
  mcsp_pkg::status_t  status;
  logic               s_fire;

  // a byte moves on unless it makes a record while the result register is stuck
  assign adv             = in_valid_q && !(result.valid && out_busy);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
  end

  mcsp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .byte_i   (in_byte_q),
    .start_i  (in_start_q),
    .result_o (result),
    .status_o (status)
  );

  mcsp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv),
    .result_i (result),
    .tready_i (m_axis_tready_i),
    .tvalid_o (m_axis_tvalid_o),
    .tdata_o  (m_axis_tdata_o),
    .tuser_o  (m_axis_tuser_o),
    .busy_o   (out_busy)
  );

  // a record is never written over one that is still waiting
  `MCSP_ASSERT_IMP(a_no_overwrite, adv && result.valid && m_axis_tvalid_o, m_axis_tready_i)
  // a start byte leaves the parser one byte into a fresh header
  `MCSP_ASSERT_NXT(a_start_restart, adv && in_start_q,
                   status.phase == mcsp_pkg::PhHeader && status.byte_pos == 4'd1)
  // malformed-length records only come out of header decode
  `MCSP_ASSERT_IMP(a_badlen_hdr,
                   result.valid && result.rec.kind == mcsp_pkg::KindBadLen && !in_start_q,
                   status.phase == mcsp_pkg::PhHeader)
  // element lists are only walked with a nonzero count
  `MCSP_ASSERT_IMP(a_list_count,
                   status.phase == mcsp_pkg::PhVert || status.phase == mcsp_pkg::PhFace,
                   status.total_nz)

endmodule

`default_nettype wire

// ===== test/mesh_chunk_stream_parser_top_tb.sv =====
// Self-checking testbench for mesh_chunk_stream_parser_top: a directed chunk plan,
// then random mesh files, noise and cut chunks, predicted by a byte-level parser
// except where pinned. Depends on mcsp_pkg and the RTL of the block; reads no files.

module mesh_chunk_stream_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBytes = 1000;
  localparam int QuietLimit  = 2000;  // cycles without any handshake
  localparam int TailCycles  = 16;
  localparam int DrainEvery  = 450;

  typedef enum logic [1:0] {FillRand, FillZero, FillOnes} fill_e;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } file_byte_t;

  // One chunk of the directed part. Where pin is set, the record raised by the
  // chunk header (or by its list count) is typed in here instead of predicted.
  typedef struct packed {
    logic            st;
    logic [15:0]     id;
    logic [31:0]     len;
    int              count;       // name chars or list entries
    int              sent;        // name chars, entries or body bytes actually sent, -1 for all
    fill_e           fill;
    logic            pin;
    mcsp_pkg::kind_e want_kind;
    logic [15:0]     want_index;
  } plan_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tuser = 1'b0;
  logic         m_tready = 1'b0;
  logic         s_tready;
  logic         m_tvalid;
  logic [183:0] m_tdata;
  logic [2:0]   m_tuser;

  mesh_chunk_stream_parser_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror
  // ---------------------------------------------------------------------------
  mcsp_pkg::phase_e ph;
  logic [47:0] hdr;
  logic [3:0]  bpos;
  logic [15:0] elem_idx;
  logic [15:0] elem_total;
  logic [31:0] skip_left;
  logic [63:0] asm_lo;
  logic [31:0] asm_hi;
  logic [4:0]  name_pos;

  function automatic void clear_parser();
    ph         = mcsp_pkg::PhHeader;
    hdr        = '0;
    bpos       = '0;
    elem_idx   = '0;
    elem_total = '0;
    skip_left  = '0;
    asm_lo     = '0;
    asm_hi     = '0;
    name_pos   = '0;
  endfunction

  function automatic void go_header();
    ph   = mcsp_pkg::PhHeader;
    bpos = '0;
  endfunction

  // Advances the parser by one byte; returns 1 when the byte closes a record.
  function automatic bit parse_byte(input logic [7:0] b, input logic st,
                                    output mcsp_pkg::rec_t rec);
    logic [15:0] tag;
    logic [15:0] id;
    logic [31:0] len;
    bit          got;
    rec = '0;
    got = 1'b0;
    if (st) clear_parser();
    tag = hdr[15:0];
    case (ph)
      mcsp_pkg::PhName: begin
        rec.kind       = mcsp_pkg::KindName;
        rec.chunk_tag  = tag;
        rec.item_index = {11'd0, name_pos};
        rec.name_char  = b;
        got            = 1'b1;
        name_pos       = name_pos + 5'd1;
        // 5-bit position wraps, so zero also ends the name
        if (b == 8'h00 || name_pos >= mcsp_pkg::NameLimit || name_pos == 5'd0) go_header();
      end
      mcsp_pkg::PhVcount, mcsp_pkg::PhFcount: begin
        if (bpos == 4'd0) begin
          elem_total = {8'h00, b};
          bpos       = 4'd1;
        end else begin
          elem_total[15:8] = b;
          if (ph == mcsp_pkg::PhVcount) rec.kind = mcsp_pkg::KindVcount;
          else rec.kind = mcsp_pkg::KindFcount;
          rec.chunk_tag  = tag;
          rec.item_index = elem_total;
          got            = 1'b1;
          elem_idx       = '0;
          bpos           = '0;
          if (elem_total == 16'd0) go_header();
          else if (ph == mcsp_pkg::PhVcount) ph = mcsp_pkg::PhVert;
          else ph = mcsp_pkg::PhFace;
        end
      end
      mcsp_pkg::PhVert: begin
        if (bpos < 4'd8) begin
          if (bpos == 4'd0) asm_lo = '0;
          asm_lo[8*bpos +: 8] = b;
        end else begin
          if (bpos == 4'd8) asm_hi = '0;
          asm_hi[8*(bpos-8) +: 8] = b;
        end
        bpos = bpos + 4'd1;
        if (bpos >= 4'd12) begin
          rec.kind       = mcsp_pkg::KindVert;
          rec.chunk_tag  = tag;
          rec.item_index = elem_idx;
          rec.coord_x    = asm_lo[31:0];
          rec.coord_y    = asm_lo[63:32];
          rec.coord_z    = asm_hi;
          got            = 1'b1;
          bpos           = '0;
          elem_idx       = elem_idx + 16'd1;
          if (elem_idx == elem_total) go_header();
        end
      end
      mcsp_pkg::PhFace: begin
        // bytes 6 and 7 are the face flags, dropped
        if (bpos < 4'd6) begin
          if (bpos == 4'd0) asm_lo = '0;
          asm_lo[8*bpos +: 8] = b;
        end
        bpos = bpos + 4'd1;
        if (bpos >= 4'd8) begin
          rec.kind       = mcsp_pkg::KindFace;
          rec.chunk_tag  = tag;
          rec.item_index = elem_idx;
          rec.corner_a   = asm_lo[15:0];
          rec.corner_b   = asm_lo[31:16];
          rec.corner_c   = asm_lo[47:32];
          got            = 1'b1;
          bpos           = '0;
          elem_idx       = elem_idx + 16'd1;
          if (elem_idx == elem_total) go_header();
        end
      end
      mcsp_pkg::PhSkip: begin
        if (skip_left > 0) skip_left = skip_left - 32'd1;
        if (skip_left == 0) go_header();
      end
      default: begin
        if (bpos == 4'd0 || bpos > 4'd5) begin
          hdr  = '0;
          bpos = '0;
        end
        hdr[8*bpos +: 8] = b;
        bpos = bpos + 4'd1;
        if (bpos >= 4'd6) begin
          bpos = '0;
          id   = hdr[15:0];
          len  = hdr[47:16];
          ph   = mcsp_pkg::PhHeader;
          if (id == mcsp_pkg::IdMain || id == mcsp_pkg::IdEdit ||
              id == mcsp_pkg::IdTriMesh) begin
            // container: next byte opens a child header
          end else if (id == mcsp_pkg::IdObject) begin
            ph       = mcsp_pkg::PhName;
            name_pos = '0;
          end else if (id == mcsp_pkg::IdVerts) begin
            ph = mcsp_pkg::PhVcount;
          end else if (id == mcsp_pkg::IdFaces) begin
            ph = mcsp_pkg::PhFcount;
          end else if (len < mcsp_pkg::HdrLen) begin
            rec.kind      = mcsp_pkg::KindBadLen;
            rec.chunk_tag = id;
            got           = 1'b1;
          end else if (len > mcsp_pkg::HdrLen) begin
            skip_left = len - mcsp_pkg::HdrLen;
            ph        = mcsp_pkg::PhSkip;
          end
        end
      end
    endcase
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: the file as a byte list, built before reset is released
  // ---------------------------------------------------------------------------
  file_byte_t     file_bytes[$];
  mcsp_pkg::rec_t pinned_recs[int];   // typed-in records, keyed by byte number
  int             mark_idx;           // byte that raises a chunk's header or count record
  logic           restart_due;

  plan_row_t opening_plan [24] = '{
    '{1'b1, mcsp_pkg::IdMain, 32'hFFFF_FFFF, 0, -1, FillRand, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    '{1'b0, mcsp_pkg::IdEdit, 32'h0000_0000, 0, -1, FillRand, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    '{1'b0, mcsp_pkg::IdObject, 32'd10, 3, -1, FillRand, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    '{1'b0, mcsp_pkg::IdObject, 32'd26, 20, -1, FillOnes, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    '{1'b0, mcsp_pkg::IdObject, 32'd7, 0, -1, FillRand, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    '{1'b0, mcsp_pkg::IdTriMesh, 32'd0, 0, -1, FillRand, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    '{1'b0, mcsp_pkg::IdVerts, 32'd8, 0, -1, FillRand, 1'b1,
      mcsp_pkg::KindVcount, 16'h0000},
    '{1'b0, mcsp_pkg::IdVerts, 32'd20, 1, -1, FillOnes, 1'b1,
      mcsp_pkg::KindVcount, 16'h0001},
    '{1'b0, mcsp_pkg::IdVerts, 32'd32, 2, -1, FillZero, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    '{1'b0, mcsp_pkg::IdVerts, 32'd44, 3, -1, FillRand, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    '{1'b0, mcsp_pkg::IdFaces, 32'd8, 0, -1, FillRand, 1'b1,
      mcsp_pkg::KindFcount, 16'h0000},
    '{1'b0, mcsp_pkg::IdFaces, 32'd24, 2, -1, FillOnes, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    '{1'b0, mcsp_pkg::IdFaces, 32'd32, 3, -1, FillRand, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    // short lengths raise a malformed-length record
    '{1'b0, 16'h0000, 32'd0, 0, -1, FillRand, 1'b1, mcsp_pkg::KindBadLen, 16'h0000},
    '{1'b0, 16'hFFFF, 32'd5, 0, -1, FillRand, 1'b1, mcsp_pkg::KindBadLen, 16'h0000},
    '{1'b0, 16'h1234, 32'd6, 0, -1, FillRand, 1'b0, mcsp_pkg::KindName, 16'h0000},
    '{1'b0, 16'h0002, 32'd7, 0, -1, FillOnes, 1'b0, mcsp_pkg::KindName, 16'h0000},
    '{1'b0, 16'h8001, 32'd24, 0, -1, FillRand, 1'b0, mcsp_pkg::KindName, 16'h0000},
    // huge skip, cut short; each following row but the last restarts the file
    '{1'b0, 16'hA5A5, 32'hFFFF_FFFF, 0, 9, FillRand, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    '{1'b1, mcsp_pkg::IdVerts, 32'hFFFF_FFFF, 16'hFFFF, 2, FillRand, 1'b1,
      mcsp_pkg::KindVcount, 16'hFFFF},
    '{1'b1, mcsp_pkg::IdFaces, 32'h0000_0000, 16'hFFFF, 2, FillRand, 1'b1,
      mcsp_pkg::KindFcount, 16'hFFFF},
    '{1'b1, mcsp_pkg::IdObject, 32'd12, 5, 2, FillRand, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    '{1'b1, mcsp_pkg::IdMain, 32'd6, 0, -1, FillRand, 1'b0,
      mcsp_pkg::KindName, 16'h0000},
    '{1'b0, 16'h4d4e, 32'd3, 0, -1, FillRand, 1'b1, mcsp_pkg::KindBadLen, 16'h0000}
  };

  function automatic void put_byte(input logic [7:0] b, input logic st);
    file_bytes.push_back('{start: st, data: b});
  endfunction

  function automatic logic [7:0] fill_byte(input fill_e fill);
    case (fill)
      FillZero: return 8'h00;
      FillOnes: return 8'hFF;
      default:  return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic take_start();
    logic st;
    st          = restart_due;
    restart_due = 1'b0;
    return st;
  endfunction

  function automatic logic [15:0] rand_id();
    case ($urandom_range(0, 7))
      0:       return mcsp_pkg::IdMain;
      1:       return mcsp_pkg::IdEdit;
      2:       return mcsp_pkg::IdObject;
      3:       return mcsp_pkg::IdTriMesh;
      4:       return mcsp_pkg::IdVerts;
      5:       return mcsp_pkg::IdFaces;
      6:       return 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Header, then a body shaped by the id. Lengths of known chunks are not used.
  function automatic void emit_chunk(input logic st, input logic [15:0] id,
                                     input logic [31:0] len, input int count,
                                     input int sent, input fill_e fill);
    longint body;
    int     n;
    int     k;
    put_byte(id[7:0], st);
    put_byte(id[15:8], 1'b0);
    for (k = 0; k < 4; k++) put_byte(len[8*k +: 8], 1'b0);
    mark_idx = file_bytes.size() - 1;
    n = (sent >= 0 && sent < count) ? sent : count;
    if (id == mcsp_pkg::IdMain || id == mcsp_pkg::IdEdit || id == mcsp_pkg::IdTriMesh) begin
      return;
    end else if (id == mcsp_pkg::IdObject) begin
      for (k = 0; k < n; k++)
        put_byte(fill == FillOnes ? 8'hFF : 8'($urandom_range(1, 255)), 1'b0);
      if (sent < 0 && count < mcsp_pkg::NameLimit) put_byte(8'h00, 1'b0);
    end else if (id == mcsp_pkg::IdVerts || id == mcsp_pkg::IdFaces) begin
      put_byte(8'(count), 1'b0);
      put_byte(8'(count >> 8), 1'b0);
      mark_idx = file_bytes.size() - 1;
      for (k = 0; k < n * ((id == mcsp_pkg::IdVerts) ? 12 : 8); k++)
        put_byte(fill_byte(fill), 1'b0);
    end else if (len > mcsp_pkg::HdrLen) begin
      body = longint'(len) - 6;
      if (sent >= 0 && sent < body) body = sent;
      for (k = 0; k < body; k++) put_byte(fill_byte(fill), 1'b0);
    end
  endfunction

  // A well-formed file: main and editor containers, then one to three objects.
  function automatic void emit_file();
    int nm;
    emit_chunk(take_start() | ($urandom_range(0, 3) == 0), mcsp_pkg::IdMain, $urandom, 0, -1,
               FillRand);
    emit_chunk(1'b0, mcsp_pkg::IdEdit, $urandom, 0, -1, FillRand);
    repeat ($urandom_range(1, 3)) begin
      nm = ($urandom_range(0, 7) == 0) ? int'(mcsp_pkg::NameLimit) :
                                         $urandom_range(0, mcsp_pkg::NameLimit - 1);
      emit_chunk(1'b0, mcsp_pkg::IdObject, $urandom, nm, -1, FillRand);
      emit_chunk(1'b0, mcsp_pkg::IdTriMesh, $urandom, 0, -1, FillRand);
      emit_chunk(1'b0, mcsp_pkg::IdVerts, $urandom, $urandom_range(0, 6), -1, FillRand);
      if ($urandom_range(0, 2) == 0)
        emit_chunk(1'b0, 16'($urandom_range(0, 65535)), $urandom_range(0, 30), 0, -1, FillRand);
      emit_chunk(1'b0, mcsp_pkg::IdFaces, $urandom, $urandom_range(0, 5), -1, FillRand);
    end
  endfunction

  function automatic void emit_random(input int target);
    int pick;
    while (file_bytes.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        emit_file();
      end else if (pick < 78) begin
        emit_chunk(take_start(), rand_id(), $urandom_range(0, 40), $urandom_range(0, 6), -1,
                   FillRand);
      end else if (pick < 88) begin
        // any length, cut after a few entries, then restart the file
        emit_chunk(take_start(), rand_id(), $urandom, $urandom_range(0, 65535),
                   $urandom_range(0, 3), fill_e'($urandom_range(0, 2)));
        restart_due = 1'b1;
      end else if (pick < 95) begin
        put_byte(8'($urandom_range(0, 255)), take_start());
        repeat ($urandom_range(0, 11))
          put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        restart_due = 1'b1;
      end else begin
        // header broken off part way
        put_byte(8'(rand_id() >> (8 * $urandom_range(0, 1))), take_start());
        repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)), 1'b0);
        restart_due = 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  mcsp_pkg::rec_t pending_recs[$];
  int   mismatches = 0;
  int   bytes_taken = 0;
  int   quiet_cycles = 0;
  int   snd_run = 0;
  int   rcv_run = 0;
  mcsp_pkg::rec_t want;
  mcsp_pkg::rec_t made;
  bit   made_ok;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] exp_val);
    if (seen !== exp_val)
      report_mismatch($sformatf("%s got %0h want %0h (tag %0h index %0d)", name, seen,
                                exp_val, want.chunk_tag, want.item_index));
  endtask

  // Picks an idle gap, with now and then a stretch of back-to-back words.
  function automatic int pick_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      run = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // Both handshakes are sampled at the edge; a result never comes from the byte
  // taken at the same edge, so the order of the two parts does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_tvalid && m_tready) begin
        if (pending_recs.size() == 0) begin
          report_mismatch($sformatf("record kind %0d tag %0h with none pending", m_tuser,
                                    m_tdata[15:0]));
        end else begin
          want = pending_recs.pop_front();
          check_field("record_kind", {29'd0, m_tuser}, {29'd0, want.kind});
          check_field("chunk_tag", {16'd0, m_tdata[15:0]}, {16'd0, want.chunk_tag});
          check_field("item_index", {16'd0, m_tdata[31:16]}, {16'd0, want.item_index});
          check_field("coord_x", m_tdata[63:32], want.coord_x);
          check_field("coord_y", m_tdata[95:64], want.coord_y);
          check_field("coord_z", m_tdata[127:96], want.coord_z);
          check_field("corner_a", {16'd0, m_tdata[143:128]}, {16'd0, want.corner_a});
          check_field("corner_b", {16'd0, m_tdata[159:144]}, {16'd0, want.corner_b});
          check_field("corner_c", {16'd0, m_tdata[175:160]}, {16'd0, want.corner_c});
          check_field("name_char", {24'd0, m_tdata[183:176]}, {24'd0, want.name_char});
        end
      end
      if (s_tvalid && s_tready) begin
        made_ok = parse_byte(s_tdata, s_tuser, made);
        if (pinned_recs.exists(bytes_taken)) pending_recs.push_back(pinned_recs[bytes_taken]);
        else if (made_ok) pending_recs.push_back(made);
        bytes_taken++;
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  initial begin
    int             i;
    int             gap;
    int             opening_end;
    plan_row_t      row;
    mcsp_pkg::rec_t pin;
    clear_parser();
    restart_due = 1'b0;
    foreach (opening_plan[r]) begin
      row = opening_plan[r];
      emit_chunk(row.st, row.id, row.len, row.count, row.sent, row.fill);
      if (row.pin) begin
        pin            = '0;
        pin.kind       = row.want_kind;
        pin.chunk_tag  = row.id;
        pin.item_index = row.want_index;
        pinned_recs[mark_idx] = pin;
      end
    end
    opening_end = file_bytes.size();
    restart_due = 1'b1;
    emit_random(opening_end + RandomBytes);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < file_bytes.size(); i++) begin
      // hold off now and then until every pending record has come out
      if (i >= opening_end && (i - opening_end) % DrainEvery == 0) begin
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending_recs.size() != 0);
        @(posedge clk);
      end
      gap = pick_gap(snd_run);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= file_bytes[i].data;
      s_tuser  <= file_bytes[i].start;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    s_tvalid <= 1'b0;

    do @(negedge clk); while (pending_recs.size() != 0);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = pick_gap(rcv_run);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

endmodule
